>>> hw/rtl/ffs_pkg.sv
// Package for the font format sniffer: types, format codes, signatures and the classifier.
`timescale 1ns / 1ps
`default_nettype none

package ffs_pkg;

   localparam int HDR_LEN       = 14;
   localparam int WIN_LEN       = 5;
   localparam int COUNT_W       = 10;
   localparam int SCAN_LIMIT_DEF = 500;

   typedef logic [HDR_LEN-1:0][7:0] hdr_type;
   typedef logic [WIN_LEN-1:0][7:0] win_type;

   typedef enum logic [3:0] {
      FMT_INVALID     = 4'd0,
      FMT_TRUETYPE    = 4'd1,
      FMT_OTF_CFF     = 4'd2,
      FMT_SFNT        = 4'd3,
      FMT_TYPE1       = 4'd4,
      FMT_PCF         = 4'd5,
      FMT_BDF         = 4'd6,
      FMT_WINDOWS_FNT = 4'd7,
      FMT_PFR         = 4'd8,
      FMT_TYPE42      = 4'd9
   } fmt_type;

   // Signature strings, left-justified in 96 bits (first character in the top byte).
   localparam logic [95:0] PAT_ADOBEFONT = "PS-AdobeFont";
   localparam logic [95:0] PAT_FONTTYPE  = {"FontType", 32'h0};
   localparam logic [95:0] PAT_STARTFONT = {"STARTFONT", 24'h0};
   localparam logic [95:0] PAT_ADOBE     = {"-Adobe-", 40'h0};

   localparam logic [31:0] MAGIC_TTF   = 32'h0001_0000;
   localparam logic [31:0] MAGIC_OTTO  = "OTTO";
   localparam logic [31:0] MAGIC_WOFF  = "wOFF";
   localparam logic [31:0] MAGIC_WOFF2 = "wOF2";
   localparam logic [31:0] MAGIC_PCF   = {8'h01, "fcp"};
   localparam logic [31:0] MAGIC_PFR   = "PFR0";
   localparam logic [31:0] MAGIC_PSHDR = "%!PS";
   localparam logic [7:0]  PFB_MARK    = 8'h80;
   localparam logic [7:0]  MZ_M        = 8'h4D;
   localparam logic [7:0]  MZ_Z        = 8'h5A;

   // Four header bytes starting at off against a big-endian word.
   function automatic logic four(hdr_type h, int off, logic [31:0] val);
      logic ok;
      ok = 1'b1;
      for (int k = 0; k < 4; k++) begin
         if (h[4'(off + k)] != val[8*(3-k) +: 8]) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   // The first len characters of a left-justified pattern against the header at off.
   function automatic logic hdr_match(hdr_type h, int off, logic [95:0] pat, int len);
      logic ok;
      ok = 1'b1;
      for (int k = 0; k < 12; k++) begin
         if (k < len && h[4'(off + k)] != pat[8*(11-k) +: 8]) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   // Priority classification of a finished file.
   function automatic fmt_type classify(hdr_type h, logic [COUNT_W-1:0] size, logic marker);
      fmt_type code;
      code = FMT_INVALID;
      if (size < 10'd4) begin
         code = FMT_INVALID;
      end else if (four(h, 0, MAGIC_TTF)) begin
         code = FMT_TRUETYPE;
      end else if (four(h, 0, MAGIC_OTTO)) begin
         code = FMT_OTF_CFF;
      end else if (four(h, 0, MAGIC_WOFF)) begin
         if (size >= 10'd8 && four(h, 4, MAGIC_OTTO)) begin
            code = FMT_OTF_CFF;
         end else if (size >= 10'd8 && four(h, 4, MAGIC_TTF)) begin
            code = FMT_TRUETYPE;
         end else begin
            code = FMT_SFNT;
         end
      end else if (four(h, 0, MAGIC_WOFF2)) begin
         code = FMT_SFNT;
      end else if (size > 10'd2 && h[0] == PFB_MARK && h[1] == 8'h01) begin
         code = FMT_TYPE1;
      end else if (size > 10'd14 && h[0] == "%" && h[1] == "!" &&
                   (hdr_match(h, 2, PAT_ADOBEFONT, 12) || hdr_match(h, 2, PAT_FONTTYPE, 8))) begin
         code = FMT_TYPE1;
      end else if (size > 10'd4 && four(h, 0, MAGIC_PCF)) begin
         code = FMT_PCF;
      end else if (size > 10'd9 && hdr_match(h, 0, PAT_STARTFONT, 9)) begin
         code = FMT_BDF;
      end else if (size > 10'd2 && ((h[0] == 8'h00 && h[1] == 8'h00) ||
                                    (h[0] == MZ_M && h[1] == MZ_Z))) begin
         code = FMT_WINDOWS_FNT;
      end else if (size > 10'd4 && four(h, 0, MAGIC_PFR)) begin
         code = FMT_PFR;
      end else if (size > 10'd20 && four(h, 0, MAGIC_PSHDR) &&
                   hdr_match(h, 4, PAT_ADOBE, 7) && marker) begin
         code = FMT_TYPE42;
      end
      return code;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/font_format_sniffer.sv
// Font format sniffer: byte stream in, one format code out per file.
// The format code of a file goes from the accepted request carrying its last byte through the
// input register, then the result register, onto the response channel.
// Throughput: one byte request per cycle; the result register holds a code while the
// next file's bytes keep flowing, and only a last byte waits on a full result register.
// Reset is synchronous and active high and clears all file state and both valid flags.
`timescale 1ns / 1ps
`default_nettype none

module font_format_sniffer #(
   parameter int SCAN_LIMIT = ffs_pkg::SCAN_LIMIT_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // Request channel: tdata = data_byte[7:0]; tlast = last_byte.
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,
   input  wire logic       req_tlast,
   // Response channel: tdata = format_code[3:0], zero-filled to 8 bits.
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata
);

   import ffs_pkg::*;

   // Input register: one byte request parked ahead of the scan logic.
   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_data_ff;
   logic                 in_last_ff;

   // File state: header bytes, sliding window, saturating count and the marker flag.
   hdr_type              hdr_ff, hdr_in;
   win_type              win_ff, win_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 found_ff, found_in;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   fmt_type              rsp_code_ff, rsp_code_in;

   logic                 advance;
   logic                 marker_hit;

   // The parked byte moves into the file state unless it ends a file and the
   // result register is still holding an untaken code.
   assign advance    = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // A "/sfnts" match counts when the window holds "/sfnt", this byte is 's', the
   // match starts before the scan limit, and the 's' is not the file's last byte.
   assign marker_hit = !found_ff && (count_ff >= COUNT_W'(WIN_LEN)) && (in_data_ff == "s") &&
                       (win_ff[0] == "/") && (win_ff[1] == "s") && (win_ff[2] == "f") &&
                       (win_ff[3] == "n") && (win_ff[4] == "t") &&
                       ({1'b0, count_ff} < (COUNT_W+1)'(SCAN_LIMIT + WIN_LEN)) && !in_last_ff;

   always_comb begin
      in_valid_in  = in_valid_ff;
      hdr_in       = hdr_ff;
      win_in       = win_ff;
      count_in     = count_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_code_in  = rsp_code_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (advance) begin
         in_valid_in = 1'b0;
         // Header capture of the first bytes.
         for (int i = 0; i < HDR_LEN; i++) begin
            if (count_ff == COUNT_W'(i)) begin
               hdr_in[i] = in_data_ff;
            end
         end
         // Window shift, index 0 oldest.
         for (int i = 0; i < WIN_LEN - 1; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[WIN_LEN-1] = in_data_ff;
         count_in = (&count_ff) ? count_ff : count_ff + COUNT_W'(1);
         if (marker_hit) begin
            found_in = 1'b1;
         end

         if (in_last_ff) begin
            // Classify with this byte included, then start a fresh file.
            rsp_valid_in = 1'b1;
            rsp_code_in  = classify(hdr_in, count_in, found_ff);
            hdr_in       = '0;
            win_in       = '0;
            count_in     = '0;
            found_in     = 1'b0;
         end
      end

      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         hdr_ff       <= '0;
         win_ff       <= '0;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         hdr_ff       <= hdr_in;
         win_ff       <= win_in;
         count_ff     <= count_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      rsp_code_ff <= rsp_code_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_code_ff};

`ifndef SYNTH
   // A new code only appears after a last byte left the input register.
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && in_last_ff))
      else $error("response raised without a last byte");

   // The format code is always one of the defined codes.
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_tdata[3:0] <= 4'd9))
      else $error("format code out of range");

   // Finishing a file clears the byte count and marker for the next file.
   a_file_restart: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> (count_ff == '0 && !found_ff))
      else $error("file state not cleared after last byte");
`endif

endmodule

`default_nettype wire

>>> tb/font_format_sniffer_tb.sv
// Self-checking testbench for the font format sniffer: file streams in, format codes checked.
`timescale 1ns / 1ps

module font_format_sniffer_tb;

   import ffs_pkg::*;

   // The run is split into three idling phases. In the first the receiver is the
   // slow side, in the second the sender is, and in the last both run flat out.
   localparam int SEND_IDLE_PCT [3] = '{24, 64, 0};
   localparam int RECV_IDLE_PCT [3] = '{64, 24, 0};
   localparam int BYTES_PER_PHASE   = 100;
   localparam int HOLD_CYCLES       = 120;
   localparam int CYCLE_LIMIT       = 300000;
   localparam int COUNT_CEIL        = 1023;

   // Kinds of generated files. Most carry a real signature with random content
   // behind it; a near miss is redrawn as one of the signature kinds.
   typedef enum int {
      K_NOISE, K_TTF, K_OTTO, K_WOFF_OTTO, K_WOFF_TTF, K_WOFF_OTHER, K_WOFF2,
      K_PFB, K_PFA_ADOBE, K_PFA_FONTTYPE, K_PCF, K_BDF, K_FNT_ZERO, K_FNT_MZ,
      K_PFR, K_TYPE42, K_NEAR_MISS
   } file_kind_type;

   // Tracks the sniffer's file state from every accepted request and holds the
   // format codes that the block still owes on its response channel.
   class format_scoreboard;
      bit [7:0]  hdr [HDR_LEN];
      bit [7:0]  recent [WIN_LEN];
      int        byte_cnt;
      bit        marker_seen;
      bit [8:0]  marker_pos;
      fmt_type   expected_codes [$];
      int        errors;
      int        files;
      int        code_hits [10];

      function new();
         clear();
      endfunction

      function void clear();
         foreach (hdr[i]) hdr[i] = 8'h00;
         foreach (recent[i]) recent[i] = 8'h00;
         byte_cnt    = 0;
         marker_seen = 1'b0;
         marker_pos  = 9'd0;
      endfunction

      function bit text_at(int at, string s);
         for (int i = 0; i < s.len(); i++) begin
            if (hdr[at + i] != s[i]) return 1'b0;
         end
         return 1'b1;
      endfunction

      function bit word_at(int at, bit [31:0] w);
         for (int i = 0; i < 4; i++) begin
            if (hdr[at + i] != w[8*(3-i) +: 8]) return 1'b0;
         end
         return 1'b1;
      endfunction

      // First matching signature wins; size is the saturated byte count.
      function fmt_type format_of(int size);
         if (size < 4) return FMT_INVALID;
         if (word_at(0, 32'h0001_0000)) return FMT_TRUETYPE;
         if (text_at(0, "OTTO")) return FMT_OTF_CFF;
         if (text_at(0, "wOFF")) begin
            if (size >= 8 && text_at(4, "OTTO")) return FMT_OTF_CFF;
            if (size >= 8 && word_at(4, 32'h0001_0000)) return FMT_TRUETYPE;
            return FMT_SFNT;
         end
         if (text_at(0, "wOF2")) return FMT_SFNT;
         if (size > 2 && hdr[0] == 8'h80 && hdr[1] == 8'h01) return FMT_TYPE1;
         if (size > 14 && (text_at(0, "%!PS-AdobeFont") || text_at(0, "%!FontType")))
            return FMT_TYPE1;
         if (size > 4 && word_at(0, {8'h01, "fcp"})) return FMT_PCF;
         if (size > 9 && text_at(0, "STARTFONT")) return FMT_BDF;
         if (size > 2 && ((hdr[0] == 8'h00 && hdr[1] == 8'h00) ||
                          (hdr[0] == 8'h4D && hdr[1] == 8'h5A)))
            return FMT_WINDOWS_FNT;
         if (size > 4 && text_at(0, "PFR0")) return FMT_PFR;
         if (size > 20 && text_at(0, "%!PS-Adobe-") && marker_seen) return FMT_TYPE42;
         return FMT_INVALID;
      endfunction

      function void note_request(bit [7:0] b, bit lst);
         int    pos;
         int    start;
         bit    hit;
         string marker_head;
         marker_head = "/sfnt";
         pos = byte_cnt;
         if (pos < HDR_LEN) hdr[pos] = b;
         // A marker counts only if it starts early enough and something follows it.
         hit = !marker_seen && pos >= WIN_LEN && b == "s";
         for (int i = 0; i < WIN_LEN; i++) begin
            if (recent[i] != marker_head[i]) hit = 1'b0;
         end
         if (hit) begin
            start = pos - WIN_LEN;
            if (start < SCAN_LIMIT_DEF && !lst) begin
               marker_seen = 1'b1;
               marker_pos  = start[8:0];
            end
         end
         for (int i = 0; i < WIN_LEN - 1; i++) recent[i] = recent[i + 1];
         recent[WIN_LEN - 1] = b;
         byte_cnt = (pos < COUNT_CEIL) ? pos + 1 : COUNT_CEIL;
         if (lst) begin
            expected_codes.push_back(format_of(byte_cnt));
            clear();
         end
      endfunction

      function void check_response(bit [7:0] data);
         fmt_type want;
         if (expected_codes.size() == 0) begin
            $display("%0t: unexpected format code %0d, no file was finished", $time, data);
            errors++;
            return;
         end
         want = expected_codes.pop_front();
         files++;
         code_hits[want]++;
         if (data != {4'h0, want}) begin
            $display("%0t: format_code mismatch, expected %0d (%s), actual 0x%02h",
                     $time, want, want.name(), data);
            errors++;
         end
      endfunction

      function int pending();
         return expected_codes.size();
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // data_byte[7:0]
   logic       req_tlast;   // last_byte
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // format_code[3:0], zero-filled

   format_scoreboard sb = new();

   int         phase;
   int         send_idle_pct;
   int         recv_idle_pct;
   bit         hold_req;
   int         cycle_cnt;
   int         bytes_sent;
   int         phase_bytes;
   bit [7:0]   file_q [$];

   font_format_sniffer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Watchdog: the slowest legal run is far below this, so hitting it means a hang.
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d format codes outstanding",
                  cycle_cnt, sb.pending());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Every response taken at a clock edge is checked against the oldest
   // prediction. Values are read before the edge's updates land.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_response(rsp_tdata);
      end
   end

   // Response side. It stalls at the current phase's rate, and once per run it
   // holds off for a long stretch so the result register fills and the block
   // has to stall a last byte on its request side.
   initial begin
      bit hold_done;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_done) begin
            hold_done  = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Offers one byte, with random idle cycles first, and returns once the
   // request has been accepted. The valid flag is left high so back-to-back
   // requests need only one assignment per edge.
   task automatic send_byte(input bit [7:0] b, input bit lst);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= lst;
      do @(posedge clock); while (!req_tready);
      sb.note_request(b, lst);
      bytes_sent++;
      phase_bytes++;
   endtask

   task automatic send_file();
      for (int i = 0; i < file_q.size(); i++) begin
         send_byte(file_q[i], i == file_q.size() - 1);
      end
   endtask

   // Writes a string into the file buffer, cut off at the end of the file.
   function automatic void lay(int at, string s);
      for (int i = 0; i < s.len(); i++) begin
         if (at + i < file_q.size()) file_q[at + i] = s[i];
      end
   endfunction

   function automatic void lay_byte(int at, bit [7:0] b);
      if (at < file_q.size()) file_q[at] = b;
   endfunction

   function automatic void lay_word(int at, bit [31:0] w);
      for (int i = 0; i < 4; i++) lay_byte(at + i, w[8*(3-i) +: 8]);
   endfunction

   // Fills the buffer with len random bytes and stamps the signature of kind k
   // over the front. A Type 42 file of at least 17 bytes also gets a "/sfnts" marker
   // somewhere after its header, sometimes ending exactly on the last byte.
   function automatic void build_file(file_kind_type k, int len);
      int p;
      file_q.delete();
      repeat (len) file_q.push_back(8'($urandom()));
      case (k)
         K_TTF:          lay_word(0, 32'h0001_0000);
         K_OTTO:         lay(0, "OTTO");
         K_WOFF_OTTO: begin
            lay(0, "wOFF");
            lay(4, "OTTO");
         end
         K_WOFF_TTF: begin
            lay(0, "wOFF");
            lay_word(4, 32'h0001_0000);
         end
         K_WOFF_OTHER:   lay(0, "wOFF");
         K_WOFF2:        lay(0, "wOF2");
         K_PFB: begin
            lay_byte(0, 8'h80);
            lay_byte(1, 8'h01);
         end
         K_PFA_ADOBE:    lay(0, "%!PS-AdobeFont");
         K_PFA_FONTTYPE: lay(0, "%!FontType");
         K_PCF: begin
            lay_byte(0, 8'h01);
            lay(1, "fcp");
         end
         K_BDF:          lay(0, "STARTFONT");
         K_FNT_ZERO: begin
            lay_byte(0, 8'h00);
            lay_byte(1, 8'h00);
         end
         K_FNT_MZ:       lay(0, "MZ");
         K_PFR:          lay(0, "PFR0");
         K_TYPE42: begin
            lay(0, "%!PS-Adobe-");
            if (len >= 17) begin
               p = ($urandom_range(3) == 0) ? len - 6 : $urandom_range(11, len - 6);
               lay(p, "/sfnts");
            end
         end
         default: ;
      endcase
   endfunction

   // Picks a random file: mostly valid signatures with random bodies, some
   // noise, and some signatures with one bit knocked out near the front.
   task automatic send_random_file();
      file_kind_type k;
      int            len;
      int            j;
      k = file_kind_type'($urandom_range(K_NEAR_MISS));
      if (k == K_NEAR_MISS) k = file_kind_type'($urandom_range(K_TTF, K_TYPE42));
      if (k == K_TYPE42) len = $urandom_range(15, 40);
      else if ($urandom_range(7) == 0) len = $urandom_range(25, 60);
      else len = $urandom_range(1, 24);
      build_file(k, len);
      if ($urandom_range(9) == 0) begin
         j = $urandom_range((len < 11 ? len : 11) - 1);
         file_q[j] = file_q[j] ^ (8'h01 << $urandom_range(7));
      end
      send_file();
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = 8'h00;
      req_tlast     = 1'b0;
      hold_req      = 1'b0;
      phase         = 0;
      send_idle_pct = SEND_IDLE_PCT[0];
      recv_idle_pct = RECV_IDLE_PCT[0];
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed short files: a one-byte file, the size limits of the
      // two-byte checks, and the four-byte magic numbers, including a WOFF
      // too short to carry its flavor.
      file_q = '{8'hFF};
      send_file();
      file_q = '{8'h80, 8'h01};
      send_file();
      file_q = '{8'h80, 8'h01, 8'h7F};
      send_file();
      file_q = '{8'h00, 8'h01, 8'h00, 8'h00};
      send_file();
      build_file(K_OTTO, 4);
      send_file();
      build_file(K_WOFF_OTHER, 4);
      send_file();
      build_file(K_WOFF2, 4);
      send_file();

      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = SEND_IDLE_PCT[phase];
         recv_idle_pct = RECV_IDLE_PCT[phase];
         phase_bytes   = 0;
         if (phase == 2) begin
            // Long receiver stall while tiny files keep coming, so that both
            // the result and input stages fill up and back-pressure reaches
            // the request side.
            hold_req <= 1'b1;
            repeat (10) begin
               build_file(file_kind_type'($urandom_range(K_NEAR_MISS)), $urandom_range(1, 4));
               send_file();
            end
            // A marker starting exactly at the scan limit does not count,
            // even with a byte following it.
            build_file(K_NOISE, SCAN_LIMIT_DEF + 7);
            lay(0, "%!PS-Adobe-");
            lay(SCAN_LIMIT_DEF, "/sfnts");
            send_file();
         end
         while (phase_bytes < BYTES_PER_PHASE) send_random_file();
      end
      req_tvalid <= 1'b0;

      // Drain: the watchdog covers a response that never comes.
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d bytes in three idling phases; %0d format codes checked.",
               bytes_sent, sb.files);
      $display("Codes 0..9 seen: %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
               sb.code_hits[0], sb.code_hits[1], sb.code_hits[2], sb.code_hits[3],
               sb.code_hits[4], sb.code_hits[5], sb.code_hits[6], sb.code_hits[7],
               sb.code_hits[8], sb.code_hits[9]);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
